### rtl/wte_pkg.sv
// Shared types, constants and character helpers for the WordML text extractor.
`default_nettype none
package wte_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       last;
  } out_word_t;

  // one input byte's worth of results: up to four text bytes and a status word
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      nbytes;
    logic            has_status;
    logic [2:0]      status;
  } burst_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_MALFORMED = 3'd1;
  localparam logic [2:0] ST_BAD_ENT   = 3'd2;
  localparam logic [2:0] ST_DECL      = 3'd3;
  localparam logic [2:0] ST_LIMIT     = 3'd4;

  localparam logic [20:0] CODE_MAX = 21'h10ffff;

  // packed lower-case local names, first char in the low byte
  localparam logic [23:0] NM_DEL = 24'h6c6564;
  localparam logic [23:0] NM_T   = 24'h000074;
  localparam logic [23:0] NM_TAB = 24'h626174;
  localparam logic [23:0] NM_BR  = 24'h007262;
  localparam logic [23:0] NM_CR  = 24'h007263;
  localparam logic [23:0] NM_TC  = 24'h006374;
  localparam logic [23:0] NM_P   = 24'h000070;
  localparam logic [23:0] NM_TR  = 24'h007274;

  // named entities, first char in the low byte
  localparam logic [31:0] EN_AMP  = 32'h00706d61;
  localparam logic [31:0] EN_LT   = 32'h0000746c;
  localparam logic [31:0] EN_GT   = 32'h00007467;
  localparam logic [31:0] EN_QUOT = 32'h746f7571;
  localparam logic [31:0] EN_APOS = 32'h736f7061;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

endpackage
`default_nettype wire

### rtl/wte_utf8_enc.sv
// Code point range check and UTF-8 encoder for numeric entities.
`default_nettype none
module wte_utf8_enc (
  input  logic [20:0]     code_i,
  output logic            ok_o,
  output logic [3:0][7:0] bytes_o,
  output logic [2:0]      n_o
);
  import wte_pkg::*;

  always_comb begin
    ok_o = !((code_i < 21'h20) || (code_i >= 21'h7f && code_i <= 21'h9f) ||
             (code_i >= 21'hd800 && code_i <= 21'hdfff));
    bytes_o = '0;
    if (code_i <= 21'h7f) begin
      bytes_o[0] = code_i[7:0];
      n_o = 3'd1;
    end else if (code_i <= 21'h7ff) begin
      bytes_o[0] = {3'b110, code_i[10:6]};
      bytes_o[1] = {2'b10, code_i[5:0]};
      n_o = 3'd2;
    end else if (code_i <= 21'hffff) begin
      bytes_o[0] = {4'b1110, code_i[15:12]};
      bytes_o[1] = {2'b10, code_i[11:6]};
      bytes_o[2] = {2'b10, code_i[5:0]};
      n_o = 3'd3;
    end else begin
      bytes_o[0] = {5'b11110, code_i[20:18]};
      bytes_o[1] = {2'b10, code_i[17:12]};
      bytes_o[2] = {2'b10, code_i[11:6]};
      bytes_o[3] = {2'b10, code_i[5:0]};
      n_o = 3'd4;
    end
  end

endmodule
`default_nettype wire

### rtl/wte_out_buf.sv
// Result register: holds one byte's burst and hands it out a word per cycle while out_ready_i is high.
`default_nettype none
module wte_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  wte_pkg::burst_t    burst_i,
  output logic               space_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output wte_pkg::out_word_t out_o
);
  import wte_pkg::*;

  burst_t     burst_q;
  logic [2:0] ptr_q;
  logic [2:0] rem;

  assign rem         = burst_q.nbytes + {2'b0, burst_q.has_status} - ptr_q;
  assign out_valid_o = rem != 3'd0;
  assign space_o     = (rem == 3'd0) || (rem == 3'd1 && out_ready_i);

  always_comb begin
    if (ptr_q < burst_q.nbytes) begin
      out_o = '{out_byte: burst_q.bytes[ptr_q[1:0]], status: ST_OK, last: 1'b0};
    end else begin
      out_o = '{out_byte: 8'd0, status: burst_q.status, last: 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_q <= '0;
      ptr_q   <= '0;
    end else if (load_i) begin
      burst_q <= burst_i;
      ptr_q   <= '0;
    end else if (out_valid_o && out_ready_i) begin
      ptr_q <= ptr_q + 3'd1;
    end
  end

endmodule
`default_nettype wire

### rtl/wordml_text_extractor.sv
// Top level: byte-wide WordML parser state and result burst register.
// An accepted word's results are registered and shown from the next cycle.
// Throughput: one input word per cycle while each byte yields at most one
// result and the output is ready; a byte yielding more results (entity bytes
// plus part status) holds input while the result register drains.
// Reset: async active low clears parser state and sets the limit to 1048576.
`default_nettype none
module wordml_text_extractor #(
  parameter int ENTITY_NAME_MAX  = 16,
  parameter int LOCAL_NAME_LIMIT = 32,
  parameter int NESTING_MAX      = 255
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  wte_pkg::in_word_t  in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output wte_pkg::out_word_t out_o,
  input  logic               cfg_we_i,
  input  logic [24:0]        cfg_data_i
);
  import wte_pkg::*;

  localparam int NW = $clog2(NESTING_MAX + 1);
  localparam int LW = $clog2(LOCAL_NAME_LIMIT + 1);
  localparam int EW = $clog2(ENTITY_NAME_MAX + 1);
  localparam logic [NW-1:0] NMAX = NW'(NESTING_MAX);
  localparam logic [LW-1:0] LMAX = LW'(LOCAL_NAME_LIMIT);
  localparam logic [EW-1:0] EMAX = EW'(ENTITY_NAME_MAX);

  // parser modes
  localparam logic [3:0] M_TEXT = 4'd0, M_ENT = 4'd1, M_LT = 4'd2, M_BANG = 4'd3;
  localparam logic [3:0] M_BDASH = 4'd4, M_CMT = 4'd5, M_PRE = 4'd6, M_PSL = 4'd7;
  localparam logic [3:0] M_NAME = 4'd8, M_REST = 4'd9;

  // declaration matcher positions: 3..8 walk "octype", 10..14 walk "ntity"
  localparam logic [3:0] D_IDLE = 4'd0, D_LT = 4'd1, D_BANG = 4'd2, D_DOC = 4'd3;
  localparam logic [3:0] D_ENT = 4'd10;

  logic [3:0]      mode_q, mode_d;
  logic [NW-1:0]   tnest_q, tnest_d, dnest_q, dnest_d;
  logic            closing_q, closing_d, slash_q, slash_d;
  logic [1:0]      quote_q, quote_d;
  logic [23:0]     lname_q, lname_d;
  logic [LW-1:0]   llen_q, llen_d;
  logic [1:0]      dash_q, dash_d;
  logic [EW-1:0]   elen_q, elen_d;
  logic [31:0]     echars_q, echars_d;   // first four entity chars, named match
  logic            ehash_q, ehash_d, ehex_q, ehex_d, ebad_q, ebad_d, edig_q, edig_d;
  logic [20:0]     ecode_q, ecode_d;     // numeric value built a digit per byte
  logic [3:0]      dpos_q, dpos_d;
  logic            dseen_q, dseen_d;
  logic [24:0]     cnt_q, cnt_d, limit_q;
  logic [2:0]      err_q, err_d;

  logic            accept, space;
  burst_t          burst;
  logic            u_ok;
  logic [3:0][7:0] u_bytes;
  logic [2:0]      u_n;

  assign in_ready_o = space;
  assign accept     = in_valid_i && in_ready_o;

  wte_utf8_enc u_enc (.code_i(ecode_q), .ok_o(u_ok), .bytes_o(u_bytes), .n_o(u_n));

  wte_out_buf u_buf (
    .clk_i, .rst_ni, .load_i(accept), .burst_i(burst), .space_o(space),
    .out_valid_o, .out_ready_i, .out_o
  );

  always_comb begin
    logic [7:0]      c, lc;
    logic            do_tag, named_hit, num_ok;
    logic [3:0]      tmode;
    logic [2:0]      em_n;
    logic [3:0][7:0] em_b;
    logic [7:0]      dg;
    logic            dg_ok;
    logic [25:0]     nxt;
    logic [25:0]     total;
    logic            tclose, tself;

    c  = in_i.in_byte;
    lc = to_lower(c);
    mode_d = mode_q; tnest_d = tnest_q; dnest_d = dnest_q;
    closing_d = closing_q; slash_d = slash_q; quote_d = quote_q;
    lname_d = lname_q; llen_d = llen_q; dash_d = dash_q;
    elen_d = elen_q; echars_d = echars_q; ehash_d = ehash_q; ehex_d = ehex_q;
    ebad_d = ebad_q; edig_d = edig_q; ecode_d = ecode_q;
    dpos_d = dpos_q; dseen_d = dseen_q; cnt_d = cnt_q; err_d = err_q;
    do_tag = 1'b0; tmode = mode_q; em_n = 3'd0; em_b = '0;
    named_hit = 1'b0; num_ok = 1'b0; dg = 8'd0; dg_ok = 1'b0; nxt = '0;
    total = '0; tclose = closing_q; tself = slash_q;
    burst = '0;

    // declaration tracking runs on every byte
    if (lc == "<") begin
      dpos_d = D_LT;
    end else begin
      unique case (dpos_q)
        D_LT:   dpos_d = (lc == "!") ? D_BANG : D_IDLE;
        D_BANG: dpos_d = (lc == "d") ? D_DOC : (lc == "e") ? D_ENT : D_IDLE;
        4'd3:   dpos_d = (lc == "o") ? 4'd4 : D_IDLE;
        4'd4:   dpos_d = (lc == "c") ? 4'd5 : D_IDLE;
        4'd5:   dpos_d = (lc == "t") ? 4'd6 : D_IDLE;
        4'd6:   dpos_d = (lc == "y") ? 4'd7 : D_IDLE;
        4'd7:   dpos_d = (lc == "p") ? 4'd8 : D_IDLE;
        4'd8: begin
          dpos_d = D_IDLE;
          if (lc == "e") dseen_d = 1'b1;
        end
        4'd10:  dpos_d = (lc == "n") ? 4'd11 : D_IDLE;
        4'd11:  dpos_d = (lc == "t") ? 4'd12 : D_IDLE;
        4'd12:  dpos_d = (lc == "i") ? 4'd13 : D_IDLE;
        4'd13:  dpos_d = (lc == "t") ? 4'd14 : D_IDLE;
        4'd14: begin
          dpos_d = D_IDLE;
          if (lc == "y") dseen_d = 1'b1;
        end
        default: dpos_d = D_IDLE;
      endcase
    end

    if (err_q == ST_OK) begin
      case (mode_q)
        M_TEXT: begin
          if (c == "<") begin
            closing_d = 1'b0; slash_d = 1'b0; quote_d = 2'd0;
            lname_d = '0; llen_d = '0;
            mode_d = M_LT;
          end else if (tnest_q != '0 && dnest_q == '0) begin
            if (c == "&") begin
              mode_d = M_ENT; elen_d = '0; echars_d = '0;
              ehash_d = 1'b0; ehex_d = 1'b0; ebad_d = 1'b0; edig_d = 1'b0;
              ecode_d = '0;
            end else begin
              em_n = 3'd1; em_b[0] = c;
            end
          end
        end
        M_ENT: begin
          if (c == ";") begin
            if (elen_q != '0 && ehash_q) begin
              num_ok = !ebad_q && edig_q && u_ok;
              if (num_ok) begin
                em_n = u_n; em_b = u_bytes;
              end
            end else begin
              unique case (elen_q)
                EW'(2): named_hit = (echars_q == EN_LT) || (echars_q == EN_GT);
                EW'(3): named_hit = echars_q == EN_AMP;
                EW'(4): named_hit = (echars_q == EN_QUOT) || (echars_q == EN_APOS);
                default: named_hit = 1'b0;
              endcase
              if (named_hit) begin
                em_n = 3'd1;
                em_b[0] = (echars_q == EN_AMP) ? "&" : (echars_q == EN_LT) ? "<" :
                          (echars_q == EN_GT) ? ">" : (echars_q == EN_QUOT) ? "\"" : "'";
              end
            end
            if (!num_ok && !named_hit) err_d = ST_BAD_ENT;
            mode_d = M_TEXT;
          end else if (c == "<" || is_space(c) || elen_q >= EMAX) begin
            err_d = ST_BAD_ENT;
          end else begin
            if (elen_q < EW'(4)) echars_d[8*elen_q[1:0] +: 8] = c;
            if (elen_q == '0) begin
              ehash_d = c == "#";
            end else if (ehash_q) begin
              if (elen_q == EW'(1) && (c == "x" || c == "X")) begin
                ehex_d = 1'b1;
              end else begin
                if (is_digit(c)) begin
                  dg = c - "0"; dg_ok = 1'b1;
                end else if (ehex_q && (c | 8'h20) >= "a" && (c | 8'h20) <= "f") begin
                  dg = (c | 8'h20) - "a" + 8'd10; dg_ok = 1'b1;
                end
                nxt = ehex_q ? ({1'b0, ecode_q, 4'b0} + 26'(dg[3:0]))
                             : ({2'b0, ecode_q, 3'b0} + {4'b0, ecode_q, 1'b0} +
                                26'(dg[3:0]));
                edig_d = 1'b1;
                if (!dg_ok || nxt > 26'(CODE_MAX)) ebad_d = 1'b1;
                else ecode_d = nxt[20:0];
              end
            end
            elen_d = elen_q + EW'(1);
          end
        end
        M_LT: begin
          if (c == "!") mode_d = M_BANG;
          else begin tmode = M_PRE; do_tag = 1'b1; end
        end
        M_BANG: begin
          if (c == "-") mode_d = M_BDASH;
          else begin tmode = M_REST; do_tag = 1'b1; end
        end
        M_BDASH: begin
          if (c == "-") begin mode_d = M_CMT; dash_d = 2'd0; end
          else begin tmode = M_REST; do_tag = 1'b1; end
        end
        M_CMT: begin
          if (c == "-") begin
            if (dash_q < 2'd2) dash_d = dash_q + 2'd1;
          end else if (c == ">" && dash_q == 2'd2) begin
            mode_d = M_TEXT; dash_d = 2'd0;
          end else begin
            dash_d = 2'd0;
          end
        end
        default: do_tag = 1'b1;
      endcase

      // tag scanner, shared by every mode that hands a byte to the tag
      if (do_tag) begin
        mode_d = tmode;
        if (quote_q != 2'd0) begin
          if ((quote_q == 2'd1 && c == "'") || (quote_q == 2'd2 && c == "\""))
            quote_d = 2'd0;
          if (!is_space(c)) slash_d = c == "/";
        end else if (c == ">") begin
          if (llen_q >= LW'(1) && llen_q < LMAX) begin
            if (llen_q == LW'(3) && lname_q == NM_DEL) begin
              if (tclose) begin
                if (dnest_q != '0) dnest_d = dnest_q - NW'(1);
              end else if (!tself) begin
                if (dnest_q >= NMAX) err_d = ST_MALFORMED;
                else dnest_d = dnest_q + NW'(1);
              end
            end else if (dnest_q == '0) begin
              if (llen_q == LW'(1) && lname_q == NM_T) begin
                if (tclose) begin
                  if (tnest_q != '0) tnest_d = tnest_q - NW'(1);
                end else if (!tself) begin
                  if (tnest_q >= NMAX) err_d = ST_MALFORMED;
                  else tnest_d = tnest_q + NW'(1);
                end
              end else if (!tclose && llen_q == LW'(3) && lname_q == NM_TAB) begin
                em_n = 3'd1; em_b[0] = 8'h09;
              end else if (!tclose && llen_q == LW'(2) &&
                           (lname_q == NM_BR || lname_q == NM_CR)) begin
                em_n = 3'd1; em_b[0] = 8'h0a;
              end else if (tclose && llen_q == LW'(2) && lname_q == NM_TC) begin
                em_n = 3'd1; em_b[0] = 8'h09;
              end else if (tclose && ((llen_q == LW'(1) && lname_q == NM_P) ||
                                      (llen_q == LW'(2) && lname_q == NM_TR))) begin
                em_n = 3'd1; em_b[0] = 8'h0a;
              end
            end
          end
          closing_d = 1'b0; slash_d = 1'b0; quote_d = 2'd0;
          lname_d = '0; llen_d = '0;
          mode_d = M_TEXT;
        end else begin
          case (tmode)
            M_PRE, M_PSL: begin
              if (is_space(c)) begin
                mode_d = tmode;
              end else if (tmode == M_PRE && c == "/") begin
                closing_d = 1'b1; mode_d = M_PSL;
              end else if (is_alpha(c) || c == "_") begin
                mode_d = M_NAME; lname_d = {16'd0, lc}; llen_d = LW'(1);
              end else begin
                mode_d = M_REST;
                if (c == "'") quote_d = 2'd1;
                else if (c == "\"") quote_d = 2'd2;
                slash_d = c == "/";
              end
            end
            M_NAME: begin
              if (c == ":") begin
                lname_d = '0; llen_d = '0;
              end else if (is_alpha(c) || is_digit(c) || c == "_" || c == "-" ||
                           c == ".") begin
                if (llen_q < LW'(3)) lname_d[8*llen_q[1:0] +: 8] = lc;
                if (llen_q < LMAX) llen_d = llen_q + LW'(1);
              end else begin
                mode_d = M_REST;
                if (c == "'") quote_d = 2'd1;
                else if (c == "\"") quote_d = 2'd2;
                if (!is_space(c)) slash_d = c == "/";
              end
            end
            default: begin
              mode_d = M_REST;
              if (c == "'") quote_d = 2'd1;
              else if (c == "\"") quote_d = 2'd2;
              if (!is_space(c)) slash_d = c == "/";
            end
          endcase
        end
      end

      // output limit: count plus this burst must not pass the register
      if (em_n != 3'd0) begin
        total = {1'b0, cnt_q} + 26'(em_n);
        if (total > {1'b0, limit_q}) begin
          err_d = ST_LIMIT;
        end else begin
          burst.bytes  = em_b;
          burst.nbytes = em_n;
          cnt_d = total[24:0];
        end
      end
    end

    // end of part: final checks, status word, clear part state
    if (in_i.last_byte) begin
      if (err_d == ST_OK) begin
        if (mode_d == M_ENT) err_d = ST_BAD_ENT;
        else if (mode_d != M_TEXT) err_d = ST_MALFORMED;
        else if (tnest_d != '0 || dnest_d != '0) err_d = ST_MALFORMED;
      end
      burst.has_status = 1'b1;
      burst.status = dseen_d ? ST_DECL : err_d;
      mode_d = M_TEXT; tnest_d = '0; dnest_d = '0;
      closing_d = 1'b0; slash_d = 1'b0; quote_d = 2'd0;
      lname_d = '0; llen_d = '0; dash_d = '0; elen_d = '0;
      dpos_d = D_IDLE; dseen_d = 1'b0; cnt_d = '0; err_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_TEXT; tnest_q <= '0; dnest_q <= '0;
      closing_q <= 1'b0; slash_q <= 1'b0; quote_q <= '0;
      lname_q <= '0; llen_q <= '0; dash_q <= '0; elen_q <= '0;
      dpos_q <= D_IDLE; dseen_q <= 1'b0; cnt_q <= '0; err_q <= ST_OK;
      ehash_q <= 1'b0; ehex_q <= 1'b0; ebad_q <= 1'b0; edig_q <= 1'b0;
    end else if (accept) begin
      mode_q <= mode_d; tnest_q <= tnest_d; dnest_q <= dnest_d;
      closing_q <= closing_d; slash_q <= slash_d; quote_q <= quote_d;
      lname_q <= lname_d; llen_q <= llen_d; dash_q <= dash_d; elen_q <= elen_d;
      dpos_q <= dpos_d; dseen_q <= dseen_d; cnt_q <= cnt_d; err_q <= err_d;
      ehash_q <= ehash_d; ehex_q <= ehex_d; ebad_q <= ebad_d; edig_q <= edig_d;
    end
  end

  // entity payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      echars_q <= echars_d;
      ecode_q  <= ecode_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) limit_q <= 25'h100000;
    else if (cfg_we_i) limit_q <= cfg_data_i;
  end

endmodule
`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for the WordML text extractor: directed parts, then random documents.
`default_nettype none
module testbench;
  import wte_pkg::*;

  // Parser modes of the scoreboard's own copy of the extractor
  typedef enum logic [3:0] {
    PM_TEXT, PM_ENTITY, PM_LT, PM_BANG, PM_BANG_DASH, PM_COMMENT,
    PM_PRE, PM_PRE_SLASH, PM_NAME, PM_REST
  } pmode_e;

  localparam int ENT_MAX    = 16;
  localparam int NAME_LIMIT = 32;
  localparam int DEPTH_MAX  = 255;
  localparam int CYCLE_LIMIT = 600000;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_we;
  logic [24:0] cfg_data;
  in_word_t  in_word;
  out_word_t out_word;

  wordml_text_extractor dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_i(in_word),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_o(out_word),
    .cfg_we_i(cfg_we), .cfg_data_i(cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Scoreboard state: a cycle-free copy of the extractor's per-part state
  // ---------------------------------------------------------------------------
  out_word_t   text_q[$];          // words still owed by the DUT, oldest first
  logic [24:0] byte_limit;
  pmode_e      pmode;
  int unsigned t_depth, d_depth, emitted;
  bit          closing_f, slash_f, decl_hit;
  logic [1:0]  quote;
  logic [23:0] name_chars;
  int          name_len, dashes, ent_len, decl_pos;
  logic [7:0]  ent_buf[ENT_MAX];
  logic [7:0]  utf_buf[4];
  logic [2:0]  err;

  int  errors, cycles, bytes_sent, parts_sent, words_seen;
  int  status_seen[8];
  bit  send_idle, recv_idle;
  logic [7:0] part_q[$];

  function automatic bit ch_space(logic [7:0] c);
    return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
  endfunction
  function automatic bit ch_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction
  function automatic bit ch_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic logic [7:0] ch_lower(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic void clear_tag();
    closing_f = 0; slash_f = 0; quote = 0; name_chars = 0; name_len = 0;
  endfunction

  function automatic void clear_part();
    pmode = PM_TEXT; t_depth = 0; d_depth = 0; clear_tag();
    dashes = 0; ent_len = 0; decl_pos = 0; decl_hit = 0; emitted = 0; err = ST_OK;
  endfunction

  // queue n bytes of utf_buf as text, or flag the limit (all or nothing)
  function automatic void push_text(int unsigned n);
    if (err != ST_OK) return;
    if (n > byte_limit || emitted > byte_limit - n) begin
      err = ST_LIMIT;
      return;
    end
    for (int i = 0; i < n; i++) text_q.push_back('{utf_buf[i], ST_OK, 1'b0});
    emitted += n;
  endfunction

  function automatic void push_char(logic [7:0] c);
    utf_buf[0] = c;
    push_text(1);
  endfunction

  // "<!doctype" / "<!entity" detector, runs on every byte, case-blind
  function automatic void track_decl(logic [7:0] c);
    string doc_s = "<!doctype";
    string ent_s = "<!entity";
    logic [7:0] lc;
    int p;
    lc = ch_lower(c);
    p = decl_pos;
    if (lc == "<") p = 1;
    else if (p == 1) p = (lc == "!") ? 2 : 0;
    else if (p == 2) p = (lc == "d") ? 3 : (lc == "e") ? 10 : 0;
    else if (p >= 3 && p <= 8) begin
      if (lc == doc_s[p]) begin
        p++;
        if (p == 9) begin decl_hit = 1; p = 0; end
      end else p = 0;
    end else if (p >= 10 && p <= 14) begin
      if (lc == ent_s[p-7]) begin
        if (p == 14) begin decl_hit = 1; p = 0; end else p++;
      end else p = 0;
    end else p = 0;
    decl_pos = p;
  endfunction

  function automatic bit ent_is(string nm);
    if (ent_len != nm.len()) return 0;
    for (int i = 0; i < ent_len; i++) if (ent_buf[i] != nm[i]) return 0;
    return 1;
  endfunction

  // decode the collected entity into utf_buf; 0 means invalid
  function automatic int decode_ent();
    int unsigned base, code, dg;
    int i;
    logic [7:0] c;
    if (ent_len > ENT_MAX) return 0;
    if (ent_len > 0 && ent_buf[0] == "#") begin
      base = 10; code = 0; i = 1;
      if (i < ent_len && (ent_buf[i] == "x" || ent_buf[i] == "X")) begin base = 16; i++; end
      if (i == ent_len) return 0;
      for (; i < ent_len; i++) begin
        c = ent_buf[i];
        if (ch_digit(c)) dg = c - "0";
        else if (base == 16 && c >= "a" && c <= "f") dg = c - "a" + 10;
        else if (base == 16 && c >= "A" && c <= "F") dg = c - "A" + 10;
        else return 0;
        if (code > (CODE_MAX - dg) / base) return 0;
        code = code * base + dg;
      end
      // control characters and surrogates are refused
      if (code < 'h20 || (code >= 'h7f && code <= 'h9f) || (code >= 'hd800 && code <= 'hdfff))
        return 0;
      if (code <= 'h7f) begin utf_buf[0] = code[7:0]; return 1; end
      if (code <= 'h7ff) begin
        utf_buf[0] = 8'hc0 | code[10:6]; utf_buf[1] = 8'h80 | code[5:0];
        return 2;
      end
      if (code <= 'hffff) begin
        utf_buf[0] = 8'he0 | code[15:12]; utf_buf[1] = 8'h80 | code[11:6];
        utf_buf[2] = 8'h80 | code[5:0];
        return 3;
      end
      utf_buf[0] = 8'hf0 | code[20:18]; utf_buf[1] = 8'h80 | code[17:12];
      utf_buf[2] = 8'h80 | code[11:6];  utf_buf[3] = 8'h80 | code[5:0];
      return 4;
    end
    if (ent_is("amp"))  begin utf_buf[0] = "&";  return 1; end
    if (ent_is("lt"))   begin utf_buf[0] = "<";  return 1; end
    if (ent_is("gt"))   begin utf_buf[0] = ">";  return 1; end
    if (ent_is("quot")) begin utf_buf[0] = "\""; return 1; end
    if (ent_is("apos")) begin utf_buf[0] = "'";  return 1; end
    return 0;
  endfunction

  function automatic bit name_is(logic [23:0] nm, int n);
    return name_len == n && name_chars == nm;
  endfunction

  function automatic void bump_depth(ref int unsigned cnt, input bit closing, input bit self);
    if (closing) begin
      if (cnt != 0) cnt--;          // stray close stays at zero
    end else if (!self) begin
      if (cnt >= DEPTH_MAX) begin
        if (err == ST_OK) err = ST_MALFORMED;
      end else cnt++;
    end
  endfunction

  function automatic void finish_tag();
    bit in_del;
    in_del = d_depth != 0;
    if (name_len >= 1 && name_len < NAME_LIMIT) begin
      if (name_is(NM_DEL, 3)) bump_depth(d_depth, closing_f, slash_f);
      else if (!in_del && name_is(NM_T, 1)) bump_depth(t_depth, closing_f, slash_f);
      else if (!in_del && !closing_f && name_is(NM_TAB, 3)) push_char(8'h09);
      else if (!in_del && !closing_f && (name_is(NM_BR, 2) || name_is(NM_CR, 2)))
        push_char(8'h0a);
      else if (!in_del && closing_f && name_is(NM_TC, 2)) push_char(8'h09);
      else if (!in_del && closing_f && (name_is(NM_P, 1) || name_is(NM_TR, 2)))
        push_char(8'h0a);
    end
    clear_tag();
    pmode = PM_TEXT;
  endfunction

  function automatic void tag_tail(logic [7:0] c);
    if (c == "'") quote = 1;
    else if (c == "\"") quote = 2;
    if (!ch_space(c)) slash_f = (c == "/");
  endfunction

  function automatic void name_push(logic [7:0] c);
    if (name_len < 3) name_chars[8*name_len +: 8] = ch_lower(c);
    if (name_len < NAME_LIMIT) name_len++;
  endfunction

  function automatic void name_begin(logic [7:0] c);
    if (ch_alpha(c) || c == "_") begin
      pmode = PM_NAME; name_chars = 0; name_len = 0; name_push(c);
    end else begin
      pmode = PM_REST; tag_tail(c);
    end
  endfunction

  function automatic void tag_char(logic [7:0] c);
    if (quote != 0) begin
      if ((quote == 1 && c == "'") || (quote == 2 && c == "\"")) quote = 0;
      if (!ch_space(c)) slash_f = (c == "/");
      return;
    end
    if (c == ">") begin finish_tag(); return; end
    case (pmode)
      PM_PRE: begin
        if (ch_space(c)) return;
        if (c == "/") begin closing_f = 1; pmode = PM_PRE_SLASH; return; end
        name_begin(c);
      end
      PM_PRE_SLASH: begin
        if (!ch_space(c)) name_begin(c);
      end
      PM_NAME: begin
        if (c == ":") begin name_chars = 0; name_len = 0; end
        else if (ch_alpha(c) || ch_digit(c) || c == "_" || c == "-" || c == ".") name_push(c);
        else begin pmode = PM_REST; tag_tail(c); end
      end
      default: begin pmode = PM_REST; tag_tail(c); end
    endcase
  endfunction

  function automatic void parse_char(logic [7:0] c);
    int n;
    case (pmode)
      PM_TEXT: begin
        if (c == "<") begin clear_tag(); pmode = PM_LT; end
        else if (t_depth != 0 && d_depth == 0) begin
          if (c == "&") begin pmode = PM_ENTITY; ent_len = 0; end
          else push_char(c);
        end
      end
      PM_ENTITY: begin
        if (c == ";") begin
          n = decode_ent();
          if (n == 0) err = ST_BAD_ENT;
          else push_text(n);
          pmode = PM_TEXT;
        end else if (c == "<" || ch_space(c) || ent_len >= ENT_MAX) err = ST_BAD_ENT;
        else begin ent_buf[ent_len] = c; ent_len++; end
      end
      PM_LT: begin
        if (c == "!") pmode = PM_BANG;
        else begin pmode = PM_PRE; tag_char(c); end
      end
      PM_BANG: begin
        if (c == "-") pmode = PM_BANG_DASH;
        else begin pmode = PM_REST; tag_char(c); end
      end
      PM_BANG_DASH: begin
        if (c == "-") begin pmode = PM_COMMENT; dashes = 0; end
        else begin pmode = PM_REST; tag_char(c); end
      end
      PM_COMMENT: begin
        if (c == "-") begin if (dashes < 2) dashes++; end
        else if (c == ">" && dashes == 2) begin pmode = PM_TEXT; dashes = 0; end
        else dashes = 0;
      end
      default: tag_char(c);
    endcase
  endfunction

  // expected words for one accepted input word
  function automatic void predict_word(logic [7:0] c, bit lst);
    track_decl(c);
    if (err == ST_OK) parse_char(c);
    if (lst) begin
      if (err == ST_OK) begin
        if (pmode == PM_ENTITY) err = ST_BAD_ENT;
        else if (pmode != PM_TEXT) err = ST_MALFORMED;
        else if (t_depth != 0 || d_depth != 0) err = ST_MALFORMED;
      end
      text_q.push_back('{8'h00, decl_hit ? ST_DECL : err, 1'b1});
      clear_part();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: random back-pressure and the word checker
  // ---------------------------------------------------------------------------
  initial begin : drain_side
    int stall;
    out_ready = 0;
    forever begin
      stall = recv_idle ? $urandom_range(0, 13) : 0;
      if (stall != 0) begin
        out_ready = 0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : check_words
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      words_seen++;
      if (text_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word byte=%h status=%0d last=%0b",
                 $time, out_word.out_byte, out_word.status, out_word.last);
      end else begin
        want = text_q.pop_front();
        if (want.last) status_seen[want.status]++;
        if (want.out_byte != out_word.out_byte || want.status != out_word.status ||
            want.last != out_word.last) begin
          errors++;
          $display("%0t: mismatch exp byte=%h status=%0d last=%0b got byte=%h status=%0d last=%0b",
                   $time, want.out_byte, want.status, want.last,
                   out_word.out_byte, out_word.status, out_word.last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  task automatic send_byte(logic [7:0] c, bit lst);
    int gap;
    gap = send_idle ? $urandom_range(0, 13) : 0;
    if (gap != 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_word.in_byte = c;
    in_word.last_byte = lst;
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    predict_word(c, lst);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) part_q.push_back(s[i]);
  endtask

  // send part_q as one part, last flag on its final byte
  task automatic send_part();
    for (int i = 0; i < part_q.size(); i++) send_byte(part_q[i], i == part_q.size() - 1);
    part_q.delete();
    parts_sent++;
    // vary idling per part, sometimes a burst with none
    send_idle = $urandom_range(0, 3) != 0;
    recv_idle = $urandom_range(0, 3) != 0;
  endtask

  task automatic send_str(string s);
    add_str(s);
    send_part();
  endtask

  // wait until every expected word is out, then for the pipeline to settle
  task automatic drain();
    in_valid = 0;
    while (text_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(logic [24:0] v);
    drain();
    cfg_data = v;
    cfg_we = 1;
    @(negedge clk);
    cfg_we = 0;
    byte_limit = v;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_layout();
    send_str("<w:p><w:r><w:t xml:space=\"a>b\">Hi</w:t><w:tab/><W:BR/><w:cr/></w:r></w:p>");
    send_str("<w:tr><w:tc></w:tc></w:tr><tab></tab></tc>");
    send_str("<t>a<del>b<t>c</t></del>d</t><!-- <t>x</t> -- ->-->");
    add_str("<t>");
    part_q.push_back(8'hef); part_q.push_back(8'hbb); part_q.push_back(8'hbf);
    part_q.push_back(8'h00); part_q.push_back(8'hff);
    add_str("</t>");
    send_part();
  endtask

  task automatic test_entities();
    send_str("<t>&amp;&lt;&gt;&quot;&apos;&#65;&#xe9;&#X20AC;&#x10FFFF;&#1114111;</t>");
    send_str("<t>&#x7f;</t>");
    send_str("<t>&#31;</t>");
    send_str("<t>&#xD800;</t>");
    send_str("<t>&#x110000;</t>");
    send_str("<t>&#;</t>");
    send_str("<t>&bogus;</t>");
    send_str("<t>&am p;</t>");
    send_str("<t>&abcdefghijklmnopq;</t>");
    send_str("<t>&#x7e;&#x9F;</t>");
    send_str("<t>&amp");
  endtask

  task automatic test_errors();
    send_str("<t");
    send_str("<!-- open");
    send_str("<!-");
    send_str("<t>open");
    send_str("<del>");
    send_str("</t></del></w:p>x");          // stray closes, no text outside t
    send_str("<1t>x</t>< t>y</t><:t>z</t>");
    send_str("<t><abcdefghijklmnopqrstuvwxyz012345>q</t><p/><t/>r");
    send_str("<!DOCTYPE x><t>a</t>");
    send_str("<t>&bad;<!EnTiTy z></t>");
    // nesting overflow: one t deeper than the block allows
    for (int i = 0; i <= DEPTH_MAX; i++) add_str("<t>");
    add_str("x");
    send_part();
    send_byte(8'h41, 1);                    // single-byte part right after
  endtask

  task automatic test_limits();
    write_limit(0);
    send_str("<t>a</t>");
    write_limit(1);
    send_str("<t>a</t>");
    send_str("<t>&#xe9;</t>");
    write_limit(3);
    send_str("<t>ab&#x20AC;</t>");
    write_limit(25'd16777216);
    send_str("<t>ok</t><w:br/>");
    write_limit(25'h1ffffff);
    send_str("<t>&#x1F600;</t>");
  endtask

  task automatic add_text();
    string good[10] = '{"&amp;", "&lt;", "&gt;", "&quot;", "&apos;", "&#65;",
                        "&#x20AC;", "&#x1F600;", "&#233;", "&#1114111;"};
    string bad[5] = '{"&#31;", "&#xD800;", "&bogus;", "&#x110000;", "&#;"};
    int n, k;
    logic [7:0] c;
    n = $urandom_range(0, 6);
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 19);
      if (k < 12) begin
        c = $urandom_range(8'h20, 8'h7e);
        if (c == "<" || c == "&") c = "x";
        part_q.push_back(c);
      end else if (k < 15) begin
        part_q.push_back($urandom_range(8'h80, 8'hff));
      end else if (k < 19) add_str(good[$urandom_range(0, 9)]);
      else if ($urandom_range(0, 3) == 0) add_str(bad[$urandom_range(0, 4)]);
    end
  endtask

  task automatic add_run();
    bool_del: begin
      bit in_del;
      in_del = $urandom_range(0, 4) == 0;
      if (in_del) add_str("<w:del w:id=\"1\">");
      add_str("<w:r>");
      case ($urandom_range(0, 5))
        0, 1, 2: begin
          add_str($urandom_range(0, 1) ? "<w:t xml:space='pre>serve'>" : "<w:t>");
          add_text();
          add_str("</w:t>");
        end
        3: add_str($urandom_range(0, 1) ? "<w:tab/>" : "<W:Tab />");
        4: add_str($urandom_range(0, 1) ? "<w:br/>" : "<w:cr/>");
        default: add_str("<!-- a-b -> --->");
      endcase
      add_str("</w:r>");
      if (in_del) add_str("</w:del>");
    end
  endtask

  task automatic random_part();
    int kind, cut;
    kind = $urandom_range(0, 9);
    if (kind == 8) begin
      repeat ($urandom_range(1, 12)) part_q.push_back($urandom_range(0, 255));
      send_part();
      return;
    end
    if ($urandom_range(0, 5) == 0) begin
      part_q.push_back(8'hef); part_q.push_back(8'hbb); part_q.push_back(8'hbf);
    end
    if (kind == 9) add_str($urandom_range(0, 1) ? "<!doctype w>" : "<!entity e>");
    repeat ($urandom_range(1, 2)) begin
      if ($urandom_range(0, 3) == 0) begin
        add_str("<w:tr><w:tc>");
        add_run();
        add_str("</w:tc></w:tr>");
      end else begin
        add_str("<w:p>");
        repeat ($urandom_range(1, 2)) add_run();
        add_str("</w:p>");
      end
    end
    if (kind == 7) begin                    // broken part: cut short
      cut = $urandom_range(1, part_q.size() - 1);
      while (part_q.size() > cut) void'(part_q.pop_back());
    end
    send_part();
  endtask

  task automatic test_random();
    int start;
    start = bytes_sent;
    while (bytes_sent - start < 190) random_part();
    drain();                                // sender holds off until all words are out
    write_limit($urandom_range(5, 40));
    while (bytes_sent - start < 300) random_part();
    write_limit(25'd1048576);
    while (bytes_sent - start < 400) random_part();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    errors = 0; cycles = 0; bytes_sent = 0; parts_sent = 0; words_seen = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    in_valid = 0; in_word = '0; cfg_we = 0; cfg_data = '0;
    send_idle = 1; recv_idle = 1;
    byte_limit = 25'd1048576;
    clear_part();
    rst_n = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    test_layout();
    test_entities();
    test_errors();
    test_limits();
    test_random();

    drain();
    repeat (8) @(posedge clk);
    $display("sent %0d bytes in %0d parts, checked %0d words", bytes_sent, parts_sent, words_seen);
    $display("part status ok/malformed/entity/decl/limit: %0d/%0d/%0d/%0d/%0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (errors == 0 && text_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
